// ===== src/b64le_pkg.sv =====
// Shared constants, types and the sextet-to-character map of the base64 line encoder.
`default_nettype none
package b64le_pkg;

    localparam int unsigned BYTE_W    = 8;
    localparam int unsigned WPL_W     = 5;
    localparam int unsigned MAX_CHARS = 6;
    localparam int unsigned CNT_W     = 3;

    localparam logic [WPL_W-1:0] WPL_MAX   = 5'd19;
    localparam logic [WPL_W-1:0] WPL_MIN   = 5'd1;
    localparam logic [WPL_W-1:0] WPL_RESET = 5'd19;

    localparam logic [BYTE_W-1:0] CH_PAD = 8'h3d;  // '='
    localparam logic [BYTE_W-1:0] CH_CR  = 8'h0d;
    localparam logic [BYTE_W-1:0] CH_LF  = 8'h0a;

    typedef logic [MAX_CHARS-1:0][BYTE_W-1:0] t_char_vec;

    // Map one 6-bit value onto the standard base64 alphabet.
    function automatic logic [BYTE_W-1:0] enc_sextet(input logic [5:0] v);
        logic [BYTE_W-1:0] w;
        w = {2'b00, v};
        if (v < 6'd26) begin
            return w + 8'd65;          // 'A'..'Z'
        end else if (v < 6'd52) begin
            return w + 8'd71;          // 'a'..'z' ('a' - 26)
        end else if (v < 6'd62) begin
            return w - 8'd4;           // '0'..'9' ('0' - 52)
        end else if (v == 6'd62) begin
            return 8'h2b;              // '+'
        end else begin
            return 8'h2f;              // '/'
        end
    endfunction

endpackage
`default_nettype wire

// ===== src/mime_base64_line_encoder.sv =====
// Top level of the streaming MIME base64 line encoder.
//
//  channel   | direction | tdata            | tlast / extra
//  ----------+-----------+------------------+-------------------------------
//  s_axis    | in        | [7:0] in_byte    | tlast = last_byte
//  m_axis    | out       | [7:0] out_char   | tlast = end_of_run
//  cfg       | in        | [4:0] words/line | i_cfg_wr_en strobes a write
//
// A request is taken into an input register; a new one can be
// taken every cycle while the input register drains into the result buffer.
// Each request yields 1 to 6 characters (about 4/3 on average plus the line
// endings), sent one per cycle on m_axis while i_m_axis_tready is high; the
// single-character output port sets the sustained rate.
// Reset (i_rst_n low at a clock edge) empties both stages, clears the group
// and line counters and sets words per line to 19.
// A stall on m_axis holds the result buffer; the input register then fills
// and s_axis tready drops until the buffer can take the pending request.
`default_nettype none
module mime_base64_line_encoder (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // configuration
    input  wire logic        i_cfg_wr_en,
    input  wire logic [4:0]  i_cfg_wr_data,
    // byte stream in
    input  wire logic        i_s_axis_tvalid,
    output      logic        o_s_axis_tready,
    input  wire logic [7:0]  i_s_axis_tdata,   // [7:0] in_byte
    input  wire logic        i_s_axis_tlast,   // last_byte
    // character stream out
    output      logic        o_m_axis_tvalid,
    input  wire logic        i_m_axis_tready,
    output      logic [7:0]  o_m_axis_tdata,   // [7:0] out_char
    output      logic        o_m_axis_tlast    // end_of_run
);

    // configuration register
    logic [b64le_pkg::WPL_W-1:0] r_wpl;
    logic [b64le_pkg::WPL_W-1:0] line_limit;

    // input register
    logic                         r_in_valid;
    logic [b64le_pkg::BYTE_W-1:0] r_in_byte;
    logic                         r_in_last;

    // encoder state
    logic [1:0]                   r_grp_pos;
    logic [3:0]                   r_resid;
    logic [b64le_pkg::WPL_W-1:0]  r_words;

    // result buffer: characters wait in slot 0 upward
    b64le_pkg::t_char_vec         r_buf;
    logic [b64le_pkg::CNT_W-1:0]  r_cnt;

    // next values from the encode logic
    b64le_pkg::t_char_vec         n_buf;
    logic [b64le_pkg::CNT_W-1:0]  n_cnt;
    logic [1:0]                   n_grp_pos;
    logic [3:0]                   n_resid;
    logic [b64le_pkg::WPL_W-1:0]  n_words;

    logic out_take;
    logic buf_load;
    logic in_take;

    // Clamp the line length to 1..19 words.
    always_comb begin
        if (r_wpl == '0) begin
            line_limit = b64le_pkg::WPL_MIN;
        end else if (r_wpl > b64le_pkg::WPL_MAX) begin
            line_limit = b64le_pkg::WPL_MAX;
        end else begin
            line_limit = r_wpl;
        end
    end

    // Handshakes: the buffer reloads when it is empty or sends its last char.
    assign out_take        = (r_cnt != '0) && i_m_axis_tready;
    assign buf_load        = r_in_valid &&
                             ((r_cnt == '0) || ((r_cnt == 3'd1) && i_m_axis_tready));
    assign o_s_axis_tready = !r_in_valid || buf_load;
    assign in_take         = i_s_axis_tvalid && o_s_axis_tready;

    assign o_m_axis_tvalid = (r_cnt != '0);
    assign o_m_axis_tdata  = r_buf[0];
    assign o_m_axis_tlast  = (r_cnt == 3'd1);

    // Encode the held byte into its characters and the next state.
    always_comb begin
        logic                        word_done;
        logic [b64le_pkg::WPL_W-1:0] wsum;
        n_buf     = '0;
        n_cnt     = 3'd1;
        word_done = 1'b0;
        wsum      = r_words + 5'd1;
        case (r_grp_pos)
            2'd1: begin
                n_buf[0]  = b64le_pkg::enc_sextet({r_resid[1:0], r_in_byte[7:4]});
                n_resid   = r_in_byte[3:0];
                n_grp_pos = 2'd2;
            end
            2'd2: begin
                n_buf[0]  = b64le_pkg::enc_sextet({r_resid, r_in_byte[7:6]});
                n_buf[1]  = b64le_pkg::enc_sextet(r_in_byte[5:0]);
                n_cnt     = 3'd2;
                n_resid   = 4'd0;
                n_grp_pos = 2'd0;
                word_done = 1'b1;
            end
            default: begin
                // first byte of a group; the unused position 3 lands here too
                n_buf[0]  = b64le_pkg::enc_sextet(r_in_byte[7:2]);
                n_resid   = {2'b00, r_in_byte[1:0]};
                n_grp_pos = 2'd1;
            end
        endcase

        // Flush a partial group with zero bits and padding.
        if (r_in_last && !word_done) begin
            if (n_grp_pos == 2'd1) begin
                n_buf[1] = b64le_pkg::enc_sextet({n_resid[1:0], 4'b0000});
                n_buf[2] = b64le_pkg::CH_PAD;
                n_buf[3] = b64le_pkg::CH_PAD;
                n_cnt    = 3'd4;
            end else begin
                n_buf[1] = b64le_pkg::enc_sextet({n_resid, 2'b00});
                n_buf[2] = b64le_pkg::CH_PAD;
                n_cnt    = 3'd3;
            end
            word_done = 1'b1;
        end

        // End the line on the message end or when the word limit is reached.
        n_words = r_words;
        if (word_done) begin
            n_words = wsum;
            if (r_in_last || (wsum >= line_limit)) begin
                n_buf[n_cnt]        = b64le_pkg::CH_CR;
                n_buf[n_cnt + 3'd1] = b64le_pkg::CH_LF;
                n_cnt               = n_cnt + 3'd2;
                n_words             = '0;
            end
        end

        if (r_in_last) begin
            n_grp_pos = 2'd0;
            n_resid   = 4'd0;
            n_words   = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wpl      <= b64le_pkg::WPL_RESET;
            r_in_valid <= 1'b0;
            r_grp_pos  <= 2'd0;
            r_resid    <= 4'd0;
            r_words    <= '0;
            r_cnt      <= '0;
        end else begin
            if (i_cfg_wr_en) begin
                r_wpl <= i_cfg_wr_data;
            end
            // input register: take a new request or drain into the buffer
            if (in_take) begin
                r_in_valid <= 1'b1;
            end else if (buf_load) begin
                r_in_valid <= 1'b0;
            end
            // advance the encoder state as the request moves on
            if (buf_load) begin
                r_grp_pos <= n_grp_pos;
                r_resid   <= n_resid;
                r_words   <= n_words;
                r_cnt     <= n_cnt;
            end else if (out_take) begin
                r_cnt <= r_cnt - 3'd1;
            end
        end
    end

    // payload registers, no reset needed
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_byte <= i_s_axis_tdata;
            r_in_last <= i_s_axis_tlast;
        end
        if (buf_load) begin
            r_buf <= n_buf;
        end else if (out_take) begin
            r_buf <= r_buf >> b64le_pkg::BYTE_W;
        end
    end

`ifndef SYNTHESIS
    a_pos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_grp_pos != 2'd3)
        else $error("group position out of range");

    a_resid_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_grp_pos == 2'd0) |-> (r_resid == 4'd0))
        else $error("residual bits left at group start");

    a_words_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_words < b64le_pkg::WPL_MAX)
        else $error("word count past line limit");

    a_load_fills: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        buf_load |=> (r_cnt != '0) && o_m_axis_tvalid)
        else $error("loaded request produced no characters");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !i_m_axis_tready) |=> o_m_axis_tvalid && $stable(r_cnt))
        else $error("result buffer moved under stall");
`endif

endmodule
`default_nettype wire

// ===== bench/tb_top.sv =====
// Self-checking bench for the MIME base64 line encoder: directed and random messages.
`default_nettype none
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int HALF_PERIOD  = 10;
    localparam int RESET_CYCLES = 6;
    localparam int STALL_LIMIT  = 2000;  // cycles with no request moving on either side
    localparam int HOLD_CYCLES  = 300;   // long output hold-off used to back up the input
    localparam int MAX_REPORTS  = 10;
    localparam int DRAIN_CYCLES = 8;

    localparam logic [8*64-1:0] B64_ALPHABET =
        "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

    typedef struct packed {
        logic [7:0] ch;
        logic       eor;
    } t_enc_char;

    logic       i_clk           = 1'b0;
    logic       i_rst_n         = 1'b0;
    logic       i_cfg_wr_en     = 1'b0;
    logic [4:0] i_cfg_wr_data   = '0;
    logic       i_s_axis_tvalid = 1'b0;
    logic       o_s_axis_tready;
    logic [7:0] i_s_axis_tdata  = '0;   // [7:0] in_byte
    logic       i_s_axis_tlast  = 1'b0; // last_byte
    logic       o_m_axis_tvalid;
    logic       i_m_axis_tready = 1'b0;
    logic [7:0] o_m_axis_tdata;         // [7:0] out_char
    logic       o_m_axis_tlast;         // end_of_run

    mime_base64_line_encoder uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_wr_en     (i_cfg_wr_en),
        .i_cfg_wr_data   (i_cfg_wr_data),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tlast  (i_s_axis_tlast),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tlast  (o_m_axis_tlast)
    );

    always #(HALF_PERIOD) i_clk = ~i_clk;

    // Encoder shadow state, kept in step with every accepted request.
    logic [4:0] wpl_model     = b64le_pkg::WPL_RESET;
    logic [1:0] grp_pos       = '0;
    logic [3:0] carry_bits    = '0;
    logic [4:0] words_on_line = '0;
    logic [7:0] pend_chars [0:b64le_pkg::MAX_CHARS-1];
    int         pend_n;

    t_enc_char  char_q [$];     // characters still owed by the encoder, oldest first
    int         mismatch_count = 0;

    int         send_idle_pct = 16;
    int         recv_idle_pct = 45;
    bit         hold_request  = 1'b0;
    int         hold_left     = 0;
    int         quiet_cycles  = 0;

    function automatic void put_char(logic [7:0] c);
        pend_chars[pend_n] = c;
        pend_n++;
    endfunction

    function automatic void put_sextet(logic [5:0] v);
        put_char(B64_ALPHABET[8*(63 - int'(v)) +: 8]);
    endfunction

    // Work out the characters one byte causes and queue them.
    function automatic void encode_byte(logic [7:0] b, logic last);
        logic      word_done;
        logic [4:0] limit;
        t_enc_char item;
        word_done = 1'b0;
        pend_n    = 0;
        case (grp_pos)
            2'd1: begin
                put_sextet({carry_bits[1:0], b[7:4]});
                carry_bits = b[3:0];
                grp_pos    = 2'd2;
            end
            2'd2: begin
                put_sextet({carry_bits, b[7:6]});
                put_sextet(b[5:0]);
                carry_bits = '0;
                grp_pos    = 2'd0;
                word_done  = 1'b1;
            end
            default: begin
                put_sextet(b[7:2]);
                carry_bits = {2'b00, b[1:0]};
                grp_pos    = 2'd1;
            end
        endcase
        // Flush a partial group with zero fill and padding.
        if (last && !word_done) begin
            if (grp_pos == 2'd1) begin
                put_sextet({carry_bits[1:0], 4'b0000});
                put_char(b64le_pkg::CH_PAD);
                put_char(b64le_pkg::CH_PAD);
            end else begin
                put_sextet({carry_bits, 2'b00});
                put_char(b64le_pkg::CH_PAD);
            end
            word_done = 1'b1;
        end
        if (word_done) begin
            words_on_line = words_on_line + 5'd1;
            limit = (wpl_model == 5'd0)              ? b64le_pkg::WPL_MIN :
                    (wpl_model > b64le_pkg::WPL_MAX) ? b64le_pkg::WPL_MAX : wpl_model;
            if (last || words_on_line >= limit) begin
                put_char(b64le_pkg::CH_CR);
                put_char(b64le_pkg::CH_LF);
                words_on_line = '0;
            end
        end
        if (last) begin
            grp_pos       = '0;
            carry_bits    = '0;
            words_on_line = '0;
        end
        for (int i = 0; i < pend_n; i++) begin
            item.ch  = pend_chars[i];
            item.eor = (i == pend_n - 1);
            char_q.push_back(item);
        end
    endfunction

    function automatic void log_mismatch(string msg);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
            $display("[%0t] mismatch: %s", $time, msg);
    endfunction

    // Compare every accepted character with the oldest one owed.
    always @(posedge i_clk) begin : check_chars
        t_enc_char want;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            if (char_q.size() == 0) begin
                log_mismatch($sformatf("unexpected char 0x%02h tlast %0b",
                                       o_m_axis_tdata, o_m_axis_tlast));
            end else begin
                want = char_q.pop_front();
                if (o_m_axis_tdata !== want.ch || o_m_axis_tlast !== want.eor)
                    log_mismatch($sformatf("char 0x%02h tlast %0b, want 0x%02h tlast %0b",
                                           o_m_axis_tdata, o_m_axis_tlast,
                                           want.ch, want.eor));
            end
        end
    end

    // Output side: random stalls, plus a long hold-off on request.
    always @(posedge i_clk) begin
        if (hold_request) begin
            hold_request = 1'b0;
            hold_left    = HOLD_CYCLES;
        end
        if (hold_left != 0) begin
            hold_left--;
            i_m_axis_tready <= 1'b0;
        end else begin
            i_m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Watchdog: end the run if nothing moves for too long.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_s_axis_tvalid && o_s_axis_tready) || (o_m_axis_tvalid && i_m_axis_tready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("FAILURE");
                $finish;
            end
        end
    end

    // Offer one byte, hold it until taken, then predict its characters.
    task automatic send_byte(input logic [7:0] b, input logic last);
        if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
            i_s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= b;
        i_s_axis_tlast  <= last;
        do @(posedge i_clk); while (!o_s_axis_tready);
        encode_byte(b, last);
    endtask

    // Send len bytes from data, first byte in the top; close marks the final one last.
    task automatic send_packed(input logic [63:0] data, input int len, input logic close);
        for (int i = 0; i < len; i++)
            send_byte(data[8*(len-1-i) +: 8], close && (i == len - 1));
    endtask

    function automatic logic [7:0] pick_byte();
        int r;
        r = $urandom_range(9);
        if (r == 0)
            return 8'h00;
        else if (r == 1)
            return 8'hff;
        return 8'($urandom);
    endfunction

    // Mostly short messages, some spanning several lines.
    function automatic int random_length();
        int r;
        r = $urandom_range(99);
        if (r < 70)
            return $urandom_range(1, 12);
        else if (r < 95)
            return $urandom_range(13, 45);
        return $urandom_range(46, 70);
    endfunction

    task automatic send_message(input int len);
        for (int i = 0; i < len; i++)
            send_byte(pick_byte(), i == len - 1);
    endtask

    // Drop valid and wait for every owed character, then wait out the drain period.
    task automatic wait_idle();
        i_s_axis_tvalid <= 1'b0;
        while (char_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // Write the line width; only called with the encoder idle.
    task automatic write_wpl(input logic [4:0] v);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= v;
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b0;
        wpl_model      = v;
    endtask

    // 60 bytes make 20 words: the reset width must break the line after 19.
    task automatic test_default_line();
        send_message(60);
        wait_idle();
    endtask

    // One-, two- and three-byte messages of all zeros and all ones.
    task automatic test_short_groups();
        write_wpl(b64le_pkg::WPL_MIN);
        send_packed(64'h00, 1, 1'b1);
        send_packed(64'hff, 1, 1'b1);
        send_packed(64'h0000, 2, 1'b1);
        send_packed(64'hffff, 2, 1'b1);
        send_packed(64'h000000, 3, 1'b1);
        send_packed(64'hffffff, 3, 1'b1);
        wait_idle();
    endtask

    // Width zero must behave like one word per line.
    task automatic test_zero_width();
        write_wpl(5'd0);
        send_packed(64'h14fb9c03, 4, 1'b1);
        wait_idle();
    endtask

    // Two words on a 3-word line, then narrow to 1: the next word must end the line.
    task automatic test_midline_change();
        write_wpl(5'd3);
        send_packed(64'h4d616e20697320, 7, 1'b0);
        wait_idle();
        write_wpl(b64le_pkg::WPL_MIN);
        send_packed(64'h8001, 2, 1'b0);
        send_byte(8'h7f, 1'b1);
        wait_idle();
    endtask

    task automatic test_random_phase(input int send_pct, input int recv_pct,
                                     input logic [4:0] wpl, input int items);
        int sent;
        int len;
        sent = 0;
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        write_wpl(wpl);
        while (sent < items) begin
            len = random_length();
            send_message(len);
            sent += len;
        end
        wait_idle();
    endtask

    // Hold the output off for a long stretch while bytes keep coming.
    task automatic test_output_stall();
        int sent;
        int len;
        sent = 0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_wpl(5'($urandom_range(2, 18)));
        hold_request = 1'b1;
        while (sent < 40) begin
            len = random_length();
            send_message(len);
            sent += len;
        end
        wait_idle();
    endtask

    initial begin
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_default_line();
        test_short_groups();
        test_zero_width();
        test_midline_change();
        test_random_phase(16, 45, 5'($urandom_range(2, 18)), 70);
        test_random_phase(45, 16, 5'd31, 70);
        test_random_phase(0, 0, b64le_pkg::WPL_MAX, 70);
        test_output_stall();

        repeat (20) @(posedge i_clk);
        if (mismatch_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
`default_nettype wire

// ===== files.f =====
src/b64le_pkg.sv
src/mime_base64_line_encoder.sv
bench/tb_top.sv
